>>> rtl/pkpf_pkg.sv
// ----------------------------------------------------------------------------
// pkpf_pkg: shared types and constants for the keypad presence poller
// Holds reset values of the configuration registers, register and command
// codes, the controller state type and the controller-to-datapath commands.
// ----------------------------------------------------------------------------
package pkpf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_PRESENT_INTERVAL = 2'd0;
    localparam logic [1:0] REG_ABSENT_INTERVAL  = 2'd1;
    localparam logic [1:0] REG_LOSS_THRESHOLD   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int INTERVAL_W  = 16;
    localparam int THRESH_W    = 4;
    localparam int TIME_W      = 32;
    localparam int KEY_W       = 8;
    localparam int HELD_W      = 3;

    // Reset values of the configuration registers
    localparam logic [INTERVAL_W-1:0] PRESENT_INTERVAL_RST = 16'd12;
    localparam logic [INTERVAL_W-1:0] ABSENT_INTERVAL_RST  = 16'd1000;
    localparam logic [THRESH_W-1:0]   LOSS_THRESHOLD_RST   = 4'd3;
    localparam logic [THRESH_W-1:0]   FAIL_COUNT_MAX       = 4'd15;

    // Item command codes
    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } pkpf_state_t;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } pkpf_cmd_t;

endpackage

>>> rtl/pkpf_ram.sv
// ----------------------------------------------------------------------------
// pkpf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pkpf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pkpf_ctrl.sv
// ----------------------------------------------------------------------------
// pkpf_ctrl: item sequencer
// Steps each transfer through capture, execute and result, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module pkpf_ctrl
    import pkpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output pkpf_cmd_t cmd
);

    pkpf_state_t state_reg;
    pkpf_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            S_RESULT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EXEC)
        else $error("accepted transfer did not move to execute");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load did not raise valid and return to idle");

    a_valid_drop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result dropped while stalled");

endmodule

>>> rtl/pkpf_dp.sv
// ----------------------------------------------------------------------------
// pkpf_dp: poll timing, presence tracking and key ring datapath
// Holds configuration, the captured item, the tracker state, the key ring
// and the result registers.
// ----------------------------------------------------------------------------
module pkpf_dp
    import pkpf_pkg::*;
#(
    parameter int RING_SLOTS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pkpf_cmd_t              cmd,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   command,
    input  logic [TIME_W-1:0]      now_ms,
    input  logic                   bus_ok,
    input  logic [KEY_W-1:0]       key_byte,
    output logic                   polled,
    output logic [KEY_W-1:0]       key_out,
    output logic                   present,
    output logic [HELD_W-1:0]      keys_held
);

    localparam int PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

    // Configuration
    logic [INTERVAL_W-1:0] present_interval_reg;
    logic [INTERVAL_W-1:0] absent_interval_reg;
    logic [THRESH_W-1:0]   loss_threshold_reg;

    // Captured item
    logic              command_reg;
    logic [TIME_W-1:0] now_reg;
    logic              bus_ok_reg;
    logic [KEY_W-1:0]  key_byte_reg;

    // Tracker state
    logic [PTR_W-1:0]    write_slot_reg, write_slot_next;
    logic [PTR_W-1:0]    read_slot_reg, read_slot_next;
    logic [THRESH_W-1:0] fail_count_reg, fail_count_next;
    logic                is_present_reg, is_present_next;
    logic [TIME_W-1:0]   next_poll_reg, next_poll_next;
    logic                polled_reg, polled_next;
    logic                read_hit_reg, read_hit_next;

    // Result registers
    logic              polled_out_reg;
    logic [KEY_W-1:0]  key_out_reg;
    logic              present_out_reg;
    logic [HELD_W-1:0] keys_held_out_reg;

    logic [TIME_W-1:0] diff;
    logic              due;
    logic              do_poll;
    logic              do_read;
    logic              ring_empty;
    logic [PTR_W-1:0]  write_after;
    logic [PTR_W-1:0]  read_after;
    logic              ring_full;
    logic              push;
    logic [THRESH_W-1:0] fail_bumped;
    logic [TIME_W-1:0] present_due;
    logic [TIME_W-1:0] absent_due;
    logic [PTR_W:0]    held_cnt;
    logic [PTR_W+3:0]  held_ext;
    logic [KEY_W-1:0]  ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_interval_reg <= PRESENT_INTERVAL_RST;
            absent_interval_reg  <= ABSENT_INTERVAL_RST;
            loss_threshold_reg   <= LOSS_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRESENT_INTERVAL: present_interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_ABSENT_INTERVAL:  absent_interval_reg  <= cfg_data[INTERVAL_W-1:0];
                REG_LOSS_THRESHOLD:   loss_threshold_reg   <= cfg_data[THRESH_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg  <= command;
            now_reg      <= now_ms;
            bus_ok_reg   <= bus_ok;
            key_byte_reg <= key_byte;
        end
        if (cmd.load_out)
        begin
            polled_out_reg    <= polled_reg;
            key_out_reg       <= read_hit_reg ? ram_rdata : '0;
            present_out_reg   <= is_present_reg;
            keys_held_out_reg <= held_ext[HELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            fail_count_reg <= '0;
            is_present_reg <= 1'b0;
            next_poll_reg  <= '0;
            polled_reg     <= 1'b0;
            read_hit_reg   <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            fail_count_reg <= fail_count_next;
            is_present_reg <= is_present_next;
            next_poll_reg  <= next_poll_next;
            polled_reg     <= polled_next;
            read_hit_reg   <= read_hit_next;
        end
    end

    assign diff        = now_reg - next_poll_reg;
    assign due         = !diff[TIME_W-1];
    assign do_poll     = cmd.execute && (command_reg == CMD_POLL) && due;
    assign ring_empty  = (write_slot_reg == read_slot_reg);
    assign do_read     = cmd.execute && (command_reg == CMD_READ) && !ring_empty;
    assign write_after = (write_slot_reg == PTR_W'(RING_SLOTS - 1)) ? '0
                                                                     : write_slot_reg + 1'b1;
    assign read_after  = (read_slot_reg == PTR_W'(RING_SLOTS - 1)) ? '0
                                                                    : read_slot_reg + 1'b1;
    assign ring_full   = (write_after == read_slot_reg);
    assign push        = do_poll && bus_ok_reg && (key_byte_reg != '0) && !ring_full;
    assign present_due = now_reg + TIME_W'(present_interval_reg);
    assign absent_due  = now_reg + TIME_W'(absent_interval_reg);
    assign fail_bumped = ((fail_count_reg < loss_threshold_reg) &&
                          (fail_count_reg != FAIL_COUNT_MAX)) ? fail_count_reg + 1'b1
                                                               : fail_count_reg;

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        fail_count_next = fail_count_reg;
        is_present_next = is_present_reg;
        next_poll_next  = next_poll_reg;
        polled_next     = polled_reg;
        read_hit_next   = read_hit_reg;
        if (cmd.execute)
        begin
            polled_next   = do_poll;
            read_hit_next = do_read;
        end
        if (do_poll)
        begin
            if (!bus_ok_reg)
            begin
                fail_count_next = fail_bumped;
                if ((fail_bumped >= loss_threshold_reg) && is_present_reg)
                begin
                    is_present_next = 1'b0;
                    write_slot_next = '0;
                    read_slot_next  = '0;
                    next_poll_next  = absent_due;
                end
                else
                begin
                    next_poll_next = is_present_reg ? present_due : absent_due;
                end
            end
            else
            begin
                fail_count_next = '0;
                is_present_next = 1'b1;
                next_poll_next  = present_due;
                if (push)
                begin
                    write_slot_next = write_after;
                end
            end
        end
        if (do_read)
        begin
            read_slot_next = read_after;
        end
    end

    // Keys held, wrapped into the ring size
    always_comb
    begin
        if (write_slot_reg >= read_slot_reg)
        begin
            held_cnt = {1'b0, write_slot_reg} - {1'b0, read_slot_reg};
        end
        else
        begin
            held_cnt = {1'b0, write_slot_reg} + (PTR_W + 1)'(RING_SLOTS)
                       - {1'b0, read_slot_reg};
        end
        held_ext = (PTR_W + 4)'(held_cnt);
    end

    pkpf_ram #(
        .WIDTH (KEY_W),
        .DEPTH (RING_SLOTS),
        .ADDR_W(PTR_W)
    ) u_ring (
        .clk  (clk),
        .we   (push),
        .waddr(write_slot_reg),
        .wdata(key_byte_reg),
        .re   (do_read),
        .raddr(read_slot_reg),
        .rdata(ram_rdata)
    );

    assign polled    = polled_out_reg;
    assign key_out   = key_out_reg;
    assign present   = present_out_reg;
    assign keys_held = keys_held_out_reg;

    a_absent_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !is_present_reg |-> write_slot_reg == read_slot_reg)
        else $error("keys held while keypad absent");

    a_good_poll_present: assert property (@(posedge clk) disable iff (!rst_n)
        do_poll && bus_ok_reg |=> is_present_reg && fail_count_reg == '0)
        else $error("successful poll did not mark keypad present");

    a_read_advances: assert property (@(posedge clk) disable iff (!rst_n)
        do_read |=> read_slot_reg != $past(read_slot_reg))
        else $error("key read did not advance the read slot");

endmodule

>>> rtl/polled_keypad_presence_fifo.sv
// ----------------------------------------------------------------------------
// polled_keypad_presence_fifo: keypad poller with presence tracking
// Paces keypad polls in wrapping millisecond time, tracks presence from bus
// success and failure, and buffers key codes in a ring.
// ----------------------------------------------------------------------------
// Each input transfer is a poll (command 0) or a key read (command 1) and
// yields exactly one result transfer. The accepting edge captures the item;
// the execute state and then the result state follow, and the result is
// loaded when the result state is left. The execute state carries the due-time
// subtract, the next poll-time add and the ring access, and the key ring's
// registered read port is why the result state follows it. No new item is
// taken until the controller returns to idle on the load edge; a stalled
// result holds back the following item's result load only, not its
// acceptance. A poll is acted on when now_ms minus the scheduled poll time
// is not negative as a signed 32-bit value; otherwise the result shows
// polled 0 and the state is unchanged. The ring holds at most RING_SLOTS-1
// keys; keys arriving when it is full are dropped, and losing presence
// empties it. Configuration must be written through cfg_we/cfg_index/cfg_data
// only while no item is in flight; the block does not enforce this.
// Indexes outside the register list are ignored.
// ----------------------------------------------------------------------------
module polled_keypad_presence_fifo
    import pkpf_pkg::*;
#(
    parameter int RING_SLOTS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [TIME_W-1:0]      now_ms,
    input  logic                   bus_ok,
    input  logic [KEY_W-1:0]       key_byte,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   polled,
    output logic [KEY_W-1:0]       key_out,
    output logic                   present,
    output logic [HELD_W-1:0]      keys_held
);

    pkpf_cmd_t cmd;

    // Sequence each transfer and own the result valid flag
    pkpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd)
    );

    // Hold config, tracker state, the key ring and the result registers
    pkpf_dp #(
        .RING_SLOTS(RING_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .command  (command),
        .now_ms   (now_ms),
        .bus_ok   (bus_ok),
        .key_byte (key_byte),
        .polled   (polled),
        .key_out  (key_out),
        .present  (present),
        .keys_held(keys_held)
    );

endmodule
